// ----- rtl/bedd_pkg.sv -----
// Package for the bitap edit distance DNA matcher.
// Holds the item structs, the token handed along the row chain and the code constants.
// No dependencies.
`default_nettype none

package bedd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 7;
    localparam int K_W         = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_MASK_A     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_C     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_G     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_T     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERRORS = 3'd5;

    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;

    typedef struct packed {
        logic [2:0] base;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic           found;
        logic [K_W-1:0] min_errors;
    } t_out_item;

    typedef struct packed {
        logic           valid;
        logic           last;
        logic [2:0]     base;
        logic           found;
        logic [K_W-1:0] min_errors;
    } t_token;

endpackage

`default_nettype wire

// ----- rtl/bitap_edit_distance_dna_unit.sv -----
// Bitap approximate DNA matcher with up to k edit errors, built as a chain of row cells.
// Throughput: one text base per cycle while the output is not stalled; a last item's
// token runs through every row cell and the output register to the output, as each
// error row uses the registered rows above it. Depends on bedd_pkg and bedd_cell.
// Reset (synchronous, active low) sets the masks to all ones, the length to 64, the
// error bound to 0, every row d to all ones shifted left by d, and empties the chain.
`default_nettype none

module bitap_edit_distance_dna_unit #(
    parameter int PATTERN_BITS = 64,
    parameter int MAX_ERRORS   = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bedd_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bedd_pkg::t_out_item                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bedd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bedd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bedd_pkg::*;

    localparam int ROW_COUNT = MAX_ERRORS + 1;
    localparam int IDX_W     = $clog2(PATTERN_BITS);

    logic [PATTERN_BITS-1:0] r_mask_a;
    logic [PATTERN_BITS-1:0] r_mask_c;
    logic [PATTERN_BITS-1:0] r_mask_g;
    logic [PATTERN_BITS-1:0] r_mask_t;
    logic [LEN_W-1:0]        r_pattern_len;
    logic [K_W-1:0]          r_max_errors;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    en;
    logic                    cfg_we;
    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        chk_full;
    logic [IDX_W-1:0]        chk_idx;
    t_token                  in_tok;

    t_token                  w_tok [0:ROW_COUNT];
    logic [PATTERN_BITS-1:0] w_old [0:ROW_COUNT];
    logic [PATTERN_BITS-1:0] w_new [0:ROW_COUNT];
    logic [ROW_COUNT-1:0]    w_active;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a      <= '1;
            r_mask_c      <= '1;
            r_mask_g      <= '1;
            r_mask_t      <= '1;
            r_pattern_len <= LEN_W'(64);
            r_max_errors  <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_MASK_A:      r_mask_a      <= i_cfg_data[PATTERN_BITS-1:0];
                REG_MASK_C:      r_mask_c      <= i_cfg_data[PATTERN_BITS-1:0];
                REG_MASK_G:      r_mask_g      <= i_cfg_data[PATTERN_BITS-1:0];
                REG_MASK_T:      r_mask_t      <= i_cfg_data[PATTERN_BITS-1:0];
                REG_PATTERN_LEN: r_pattern_len <= i_cfg_data[LEN_W-1:0];
                REG_MAX_ERRORS:  r_max_errors  <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_pattern_len == '0 || r_pattern_len > LEN_W'(PATTERN_BITS)) begin
            len_eff = LEN_W'(PATTERN_BITS);
        end else begin
            len_eff = r_pattern_len;
        end
        chk_full = len_eff - LEN_W'(1);
        chk_idx  = chk_full[IDX_W-1:0];
    end

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_comb begin
        in_tok            = '0;
        in_tok.valid      = i_in_valid;
        in_tok.last       = i_in.last;
        in_tok.base       = i_in.base;
    end

    assign w_tok[0] = in_tok;
    assign w_old[0] = '1;
    assign w_new[0] = '1;

    for (genvar g = 0; g < ROW_COUNT; g++) begin : g_row
        assign w_active[g] = (int'(r_max_errors) >= g);

        bedd_cell #(
            .W (PATTERN_BITS),
            .D (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_tok     (w_tok[g]),
            .i_old     (w_old[g]),
            .i_new     (w_new[g]),
            .i_mask_a  (r_mask_a),
            .i_mask_c  (r_mask_c),
            .i_mask_g  (r_mask_g),
            .i_mask_t  (r_mask_t),
            .i_active  (w_active[g]),
            .i_chk_idx (chk_idx),
            .o_tok     (w_tok[g+1]),
            .o_old     (w_old[g+1]),
            .o_new     (w_new[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_tok[ROW_COUNT].valid && w_tok[ROW_COUNT].last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.found      <= w_tok[ROW_COUNT].found;
            r_out.min_errors <= w_tok[ROW_COUNT].min_errors;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A result that does not report a match carries a distance of zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.min_errors == '0))
        else $error("result without a match has a nonzero distance");

    // A reported distance never exceeds the configured error bound.
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.found) |-> (o_out.min_errors <= r_max_errors))
        else $error("reported distance above the error bound");

    // The input side is held back only while a finished result waits to be taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // While the chain is held, the token leaving the last row cell does not move.
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(w_tok[ROW_COUNT]))
        else $error("row chain advanced while held");

endmodule

`default_nettype wire

// ----- rtl/bedd_cell.sv -----
// One row cell of the bitap chain: holds error row D and updates it from the token and rows that cell D-1 registered.
// Hands its old and new row and the item token to the next cell. Depends on bedd_pkg.
`default_nettype none

module bedd_cell #(
    parameter int W = 64,
    parameter int D = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  bedd_pkg::t_token        i_tok,
    input  logic [W-1:0]            i_old,
    input  logic [W-1:0]            i_new,
    input  logic [W-1:0]            i_mask_a,
    input  logic [W-1:0]            i_mask_c,
    input  logic [W-1:0]            i_mask_g,
    input  logic [W-1:0]            i_mask_t,
    input  logic                    i_active,
    input  logic [$clog2(W)-1:0]    i_chk_idx,
    output bedd_pkg::t_token        o_tok,
    output logic [W-1:0]            o_old,
    output logic [W-1:0]            o_new
);
    import bedd_pkg::*;

    localparam logic [W-1:0]   INIT   = {W{1'b1}} << D;
    localparam logic [K_W-1:0] ROW_ID = K_W'(D);

    logic [W-1:0] r_row;
    logic [W-1:0] r_old;
    logic [W-1:0] r_new;
    t_token       r_tok;

    logic [W-1:0] base_mask;
    logic [W-1:0] upd;
    logic [W-1:0] n_row;
    logic         base_ok;
    logic         hit;
    t_token       n_tok;

    always_comb begin
        case (i_tok.base)
            BASE_A: base_mask = i_mask_a;
            BASE_C: base_mask = i_mask_c;
            BASE_G: base_mask = i_mask_g;
            BASE_T: base_mask = i_mask_t;
            default: base_mask = '1;
        endcase
        base_ok = (i_tok.base <= BASE_T);
        if (D == 0) begin
            upd = (r_row << 1) | base_mask;
        end else begin
            upd = i_old & (i_old << 1) & (i_new << 1) & ((r_row << 1) | base_mask);
        end
        n_row   = (i_tok.valid && base_ok && i_active) ? upd : r_row;
        hit     = i_active && !n_row[i_chk_idx];
        n_tok   = i_tok;
        if (!i_tok.found && hit) begin
            n_tok.found      = 1'b1;
            n_tok.min_errors = ROW_ID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= INIT;
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (i_tok.valid) begin
                r_row <= i_tok.last ? INIT : n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_old <= r_row;
            r_new <= n_row;
        end
    end

    assign o_tok = r_tok;
    assign o_old = r_old;
    assign o_new = r_new;

endmodule

`default_nettype wire

// ----- tb/sv/bitap_edit_distance_dna_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the bitap edit distance DNA matcher, which streams text bases
// against a pattern and checks every match report against a cycle-free model of the rows.
// Depends on bedd_pkg and the bitap_edit_distance_dna_unit RTL.

module bitap_edit_distance_dna_unit_tb;
    import bedd_pkg::*;

    localparam int PATTERN_BITS = 64;
    localparam int MAX_ERRORS   = 15;
    localparam int LATENCY      = MAX_ERRORS + 2;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_ITEMS = 1250;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [2:0] BASE_SKIP_LO = 3'd4;
    localparam logic [2:0] BASE_SKIP_HI = 3'd7;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_in_item               i_in        = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_item              o_out;
    logic                   o_cfg_ready;

    bitap_edit_distance_dna_unit #(
        .PATTERN_BITS(PATTERN_BITS),
        .MAX_ERRORS  (MAX_ERRORS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the configuration and the error rows.
    logic [63:0] base_mask [0:3];
    logic [6:0]  pat_len;
    logic [3:0]  err_bound;
    logic [63:0] rows [0:MAX_ERRORS];
    t_out_item   pending_reports [$];

    logic [2:0]  motif [0:63];
    int          motif_eff;

    int  mismatches   = 0;
    int  items_used   = 0;
    int  reports_seen = 0;
    int  cfg_writes   = 0;
    int  phases       = 0;
    int  quiet        = 0;
    bit  no_gaps      = 1'b0;
    bit  hold_go      = 1'b0;
    bit  hold_seen    = 1'b0;
    int  hold_left    = 0;
    t_out_item want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int effective_len(input logic [6:0] len);
        return (len == 0 || len > PATTERN_BITS) ? PATTERN_BITS : int'(len);
    endfunction

    function automatic void clear_rows();
        for (int d = 0; d <= MAX_ERRORS; d++) rows[d] = {64{1'b1}} << d;
    endfunction

    function automatic void advance_rows(input logic [63:0] bm);
        logic [63:0] prev [0:MAX_ERRORS];
        for (int d = 0; d <= MAX_ERRORS; d++) prev[d] = rows[d];
        rows[0] = (prev[0] << 1) | bm;
        for (int d = 1; d <= int'(err_bound); d++) begin
            rows[d] = prev[d-1] & (prev[d-1] << 1) & (rows[d-1] << 1) & ((prev[d] << 1) | bm);
        end
    endfunction

    function automatic void predict_item(input t_in_item it);
        t_out_item rep;
        int        chk;
        if (it.base <= BASE_T) advance_rows(base_mask[it.base[1:0]]);
        if (it.last) begin
            chk = effective_len(pat_len) - 1;
            rep = '0;
            for (int t = 0; t <= int'(err_bound); t++) begin
                if (!rep.found && !rows[t][chk]) begin
                    rep.found = 1'b1;
                    rep.min_errors = K_W'(t);
                end
            end
            pending_reports.push_back(rep);
            clear_rows();
        end
    endfunction

    task automatic send_base(input logic [2:0] b, input bit lst);
        t_in_item it;
        it.base = b;
        it.last = lst;
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(it);
        if (b <= BASE_T || lst) items_used++;
        if (!no_gaps && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 3)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data,
                             input bit lower);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        case (idx)
            REG_MASK_A:      base_mask[BASE_A[1:0]] = data;
            REG_MASK_C:      base_mask[BASE_C[1:0]] = data;
            REG_MASK_G:      base_mask[BASE_G[1:0]] = data;
            REG_MASK_T:      base_mask[BASE_T[1:0]] = data;
            REG_PATTERN_LEN: pat_len = data[LEN_W-1:0];
            REG_MAX_ERRORS:  err_bound = data[K_W-1:0];
            default: ;
        endcase
        if (lower) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [63:0] ma, input logic [63:0] mc,
                             input logic [63:0] mg, input logic [63:0] mt,
                             input logic [6:0] len, input logic [3:0] k);
        logic [63:0] len_word;
        logic [63:0] k_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        k_word = {$urandom, $urandom};
        k_word[K_W-1:0] = k;
        write_reg(REG_MASK_A, ma, 1'b0);
        write_reg(REG_MASK_C, mc, 1'b0);
        write_reg(REG_MASK_G, mg, 1'b0);
        write_reg(REG_MASK_T, mt, 1'b0);
        write_reg(REG_PATTERN_LEN, len_word, 1'b0);
        write_reg(REG_MAX_ERRORS, k_word, 1'b1);
    endtask

    task automatic program_motif(input logic [6:0] len, input logic [3:0] k, input bit noisy);
        logic [63:0] m [0:3];
        motif_eff = effective_len(len);
        for (int b = 0; b < 4; b++) m[b] = '1;
        for (int i = 0; i < motif_eff; i++) m[motif[i][1:0]][i] = 1'b0;
        if (noisy) begin
            for (int b = 0; b < 4; b++) m[b] = {$urandom, $urandom};
        end
        configure(m[0], m[1], m[2], m[3], len, k);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    // Optional random prefix, then the motif with a budget of substitutions,
    // deletions and insertions and some skipped codes, ending on the base that carries last.
    task automatic send_read(input int edit_budget);
        logic [2:0] seq [$];
        int         budget;
        budget = edit_budget;
        if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 4)) seq.push_back(3'($urandom_range(3)));
        end
        for (int i = 0; i < motif_eff; i++) begin
            if ($urandom_range(99) < 4) seq.push_back(3'($urandom_range(BASE_SKIP_HI, BASE_SKIP_LO)));
            if (budget > 0 && $urandom_range(motif_eff - 1) < budget) begin
                budget--;
                case ($urandom_range(2))
                    0: seq.push_back(motif[i] ^ 3'($urandom_range(1, 3)));
                    1: ;
                    default: begin
                        seq.push_back(3'($urandom_range(3)));
                        seq.push_back(motif[i]);
                    end
                endcase
            end else begin
                seq.push_back(motif[i]);
            end
        end
        if (seq.size() == 0) seq.push_back(BASE_SKIP_LO);
        foreach (seq[j]) send_base(seq[j], j == seq.size() - 1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int j = 0; j < n; j++) send_base(3'($urandom_range(7)), j == n - 1);
    endtask

    task automatic randomize_motif();
        for (int i = 0; i < 64; i++) motif[i] = 3'($urandom_range(3));
    endtask

    task automatic test_directed();
        // Reset configuration: all-ones masks never match.
        send_base(BASE_A, 1'b0);
        send_base(BASE_C, 1'b0);
        send_base(BASE_G, 1'b1);
        wait_idle();
        motif[0] = BASE_A;
        motif[1] = BASE_C;
        motif[2] = BASE_G;
        motif[3] = BASE_T;
        program_motif(7'd4, 4'd0, 1'b0);
        send_base(BASE_A, 1'b0);
        send_base(BASE_C, 1'b0);
        send_base(BASE_G, 1'b0);
        send_base(BASE_T, 1'b1);
        wait_idle();
        program_motif(7'd4, 4'd1, 1'b0);
        send_base(BASE_A, 1'b0);
        send_base(BASE_C, 1'b0);
        send_base(BASE_C, 1'b0);
        send_base(BASE_T, 1'b1);
        // Skipped codes leave the rows alone, also when they carry last.
        send_base(BASE_A, 1'b0);
        send_base(BASE_SKIP_LO, 1'b0);
        send_base(BASE_C, 1'b0);
        send_base(BASE_G, 1'b0);
        send_base(BASE_SKIP_HI, 1'b0);
        send_base(BASE_T, 1'b0);
        send_base(BASE_SKIP_HI, 1'b1);
        wait_idle();
        configure('0, '0, '0, '0, 7'd1, 4'd15);
        send_base(BASE_T, 1'b1);
        wait_idle();
        configure('1, '1, '1, '1, 7'd0, 4'd15);
        send_base(BASE_C, 1'b0);
        send_base(BASE_G, 1'b1);
        wait_idle();
        configure('0, '1, '0, '1, 7'd127, 4'd15);
        send_base(BASE_A, 1'b0);
        send_base(BASE_G, 1'b1);
        wait_idle();
        write_reg(REG_SPARE_LO, {$urandom, $urandom}, 1'b0);
        write_reg(REG_SPARE_HI, {$urandom, $urandom}, 1'b1);
        send_base(BASE_A, 1'b1);
        wait_idle();
    endtask

    task automatic test_output_hold();
        randomize_motif();
        program_motif(7'd6, 4'd3, 1'b0);
        hold_go <= ~hold_go;
        repeat (80) send_base(3'($urandom_range(3)), $urandom_range(2) == 0);
        wait_idle();
    endtask

    task automatic test_back_to_back();
        int start;
        no_gaps = 1'b1;
        randomize_motif();
        program_motif(7'd10, 4'd2, 1'b0);
        start = items_used;
        while (items_used - start < 200) send_read($urandom_range(4));
        wait_idle();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_reads();
        int          start;
        int          phase_start;
        int          r;
        logic [6:0]  len;
        logic [3:0]  k;
        start = items_used;
        while (items_used - start < TARGET_ITEMS) begin
            wait_idle();
            r = $urandom_range(99);
            if (r < 70)      len = 7'($urandom_range(1, 12));
            else if (r < 85) len = 7'($urandom_range(13, 63));
            else if (r < 93) len = 7'd64;
            else if (r < 97) len = 7'd0;
            else             len = 7'($urandom_range(65, 127));
            r = $urandom_range(99);
            if (r < 15)      k = 4'd0;
            else if (r < 30) k = 4'd15;
            else             k = 4'($urandom_range(15));
            randomize_motif();
            program_motif(len, k, $urandom_range(9) == 0);
            phase_start = items_used;
            while (items_used - phase_start < 100) begin
                if ($urandom_range(99) < 80) send_read($urandom_range(int'(k) + 2));
                else send_noise();
            end
            phases++;
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report, expected none actual found %0d min_errors %0d",
                         $time, o_out.found, o_out.min_errors);
            end else begin
                want = pending_reports.pop_front();
                if (o_out.found !== want.found) begin
                    mismatches++;
                    $display("%0t: found expected %0d actual %0d", $time, want.found, o_out.found);
                end
                if (o_out.min_errors !== want.min_errors) begin
                    mismatches++;
                    $display("%0t: min_errors expected %0d actual %0d",
                             $time, want.min_errors, o_out.min_errors);
                end
            end
        end
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_gaps && ($urandom_range(99) < 16);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < 4; b++) base_mask[b] = '1;
        pat_len = 7'd64;
        err_bound = 4'd0;
        clear_rows();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_output_hold();
        test_back_to_back();
        test_random_reads();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("Streamed %0d bases over %0d random configurations with %0d register writes,",
                 items_used, phases, cfg_writes);
        $display("including a long output hold and a gap-free stretch; %0d reports checked.",
                 reports_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
